// ===== hw/rtl/dihedral_angle_unit_macros.svh =====
// assertion macros for the dihedral angle unit
// included by files that carry concurrent checks, no other dependencies
`ifndef DIHEDRAL_ANGLE_UNIT_MACROS_SVH
`define DIHEDRAL_ANGLE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DAU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("dau check failed");
`define DAU_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("dau check failed");
`else
`define DAU_ASSERT(lbl, clk, rstn, prop)
`define DAU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/dau_pkg.sv =====
// shared types and constants of the dihedral angle unit
// beat structs between pipeline sections and the cordic angle table
package dau_pkg;

    localparam int NORM_BITS  = 30;
    localparam int PAIR_BITS  = 31;
    localparam int CORDIC_STEPS = 24;
    localparam int ACC_FRAC   = 24;
    localparam int ANGLE_W    = 16;
    localparam int CRD_W      = 36;
    localparam int ISQ_STAGES = 16;
    localparam int CRD_STAGES = CORDIC_STEPS / 2;
    localparam logic [31:0] DEG180_Q = 32'(64'd180 << ACC_FRAC);
    localparam logic [31:0] DEG90_Q  = 32'(64'd90 << ACC_FRAC);
    localparam logic [31:0] ROUND_HALF = 32'(64'd1 << (ACC_FRAC - 1));

    typedef struct packed {
        logic signed [NORM_BITS:0] p0;
        logic signed [NORM_BITS:0] p1;
        logic signed [NORM_BITS:0] p2;
        logic signed [NORM_BITS:0] q0;
        logic signed [NORM_BITS:0] q1;
        logic signed [NORM_BITS:0] q2;
        logic                      neg;
        logic                      degen;
    } norm_beat_t;

    typedef struct packed {
        logic [63:0]               sq;
        logic signed [PAIR_BITS:0] dot;
        logic                      neg;
        logic                      degen;
    } pair_beat_t;

    typedef struct packed {
        logic [31:0]               root;
        logic signed [PAIR_BITS:0] dot;
        logic                      neg;
        logic                      degen;
    } root_beat_t;

    // atan(2^-i) in degrees, unsigned q24
    function automatic logic [31:0] atan_q24(input logic [4:0] idx);
        case (idx)
            5'd0:  return 32'd754974720;
            5'd1:  return 32'd445687602;
            5'd2:  return 32'd235489088;
            5'd3:  return 32'd119537938;
            5'd4:  return 32'd60000934;
            5'd5:  return 32'd30029717;
            5'd6:  return 32'd15018523;
            5'd7:  return 32'd7509720;
            5'd8:  return 32'd3754917;
            5'd9:  return 32'd1877466;
            5'd10: return 32'd938734;
            5'd11: return 32'd469367;
            5'd12: return 32'd234684;
            5'd13: return 32'd117342;
            5'd14: return 32'd58671;
            5'd15: return 32'd29335;
            5'd16: return 32'd14668;
            5'd17: return 32'd7334;
            5'd18: return 32'd3667;
            5'd19: return 32'd1833;
            5'd20: return 32'd917;
            5'd21: return 32'd458;
            5'd22: return 32'd229;
            5'd23: return 32'd115;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/dau_normals.sv =====
// plane normals, sign test and normal scaling, six register stages
// depends on dau_pkg
module dau_normals #(
    parameter int COORD_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [12*COORD_BITS-1:0]    in_pts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dau_pkg::norm_beat_t         out_beat
);
    import dau_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int LB   = (NW + 1) / 2;
    localparam int HB   = NW - LB;
    localparam int LOP  = LB + 1 + DW;
    localparam int HIP  = HB + DW;
    localparam int TW   = NW + DW + 3;
    localparam int LW   = $clog2(NW + 1);
    localparam int SW   = NW + NORM_BITS;
    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: edge vectors
    logic signed [COORD_BITS-1:0] pt[12];
    logic signed [DW-1:0] u_reg[3], v_reg[3], w_reg[3];

    always_comb begin
        for (int j = 0; j < 12; j++) begin
            pt[j] = $signed(in_pts[j*COORD_BITS +: COORD_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= DW'(pt[3+i]) - DW'(pt[i]);
                v_reg[i] <= DW'(pt[6+i]) - DW'(pt[3+i]);
                w_reg[i] <= DW'(pt[9+i]) - DW'(pt[6+i]);
            end
        end
    end

    // stage 1: cross product terms
    logic signed [PW-1:0] m1a_reg[3], m1b_reg[3], m2a_reg[3], m2b_reg[3];
    logic signed [DW-1:0] w1_reg[3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                m1a_reg[i] <= u_reg[(i+1)%3] * v_reg[(i+2)%3];
                m1b_reg[i] <= u_reg[(i+2)%3] * v_reg[(i+1)%3];
                m2a_reg[i] <= v_reg[(i+1)%3] * w_reg[(i+2)%3];
                m2b_reg[i] <= v_reg[(i+2)%3] * w_reg[(i+1)%3];
                w1_reg[i]  <= w_reg[i];
            end
        end
    end

    // stage 2: normals
    logic signed [NW-1:0] n1_reg[3], n2_reg[3];
    logic signed [DW-1:0] w2_reg[3];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                n1_reg[i] <= NW'(m1a_reg[i]) - NW'(m1b_reg[i]);
                n2_reg[i] <= NW'(m2a_reg[i]) - NW'(m2b_reg[i]);
                w2_reg[i] <= w1_reg[i];
            end
        end
    end

    // stage 3: split triple product terms, magnitudes
    logic signed [LOP-1:0] tlo_reg[3];
    logic signed [HIP-1:0] thi_reg[3];
    logic [NW-1:0]         mag_reg[6];
    logic [5:0]            sgn_reg;
    logic                  degen3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                tlo_reg[i] <= $signed({1'b0, n1_reg[i][LB-1:0]}) * w2_reg[i];
                thi_reg[i] <= $signed(n1_reg[i][NW-1:LB]) * w2_reg[i];
                mag_reg[i]   <= n1_reg[i][NW-1] ? $unsigned(-n1_reg[i]) : $unsigned(n1_reg[i]);
                mag_reg[3+i] <= n2_reg[i][NW-1] ? $unsigned(-n2_reg[i]) : $unsigned(n2_reg[i]);
                sgn_reg[i]   <= n1_reg[i][NW-1];
                sgn_reg[3+i] <= n2_reg[i][NW-1];
            end
            degen3_reg <= (n1_reg[0] == '0 && n1_reg[1] == '0 && n1_reg[2] == '0) ||
                          (n2_reg[0] == '0 && n2_reg[1] == '0 && n2_reg[2] == '0);
        end
    end

    // stage 4: sign of the triple product, leading one of each normal
    logic signed [TW-1:0] tsum;
    logic [NW-1:0]        or1, or2;
    logic [LW-1:0]        len1, len2;
    logic [NW-1:0]        mag4_reg[6];
    logic [5:0]           sgn4_reg;
    logic [LW-1:0]        len_reg[2];
    logic                 neg4_reg, degen4_reg;

    always_comb begin
        tsum = '0;
        for (int i = 0; i < 3; i++) begin
            tsum = tsum + (TW'(thi_reg[i]) <<< LB) + TW'(tlo_reg[i]);
        end
        or1  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        or2  = mag_reg[3] | mag_reg[4] | mag_reg[5];
        len1 = '0;
        len2 = '0;
        for (int b = 0; b < NW; b++) begin
            if (or1[b]) begin
                len1 = LW'(b + 1);
            end
            if (or2[b]) begin
                len2 = LW'(b + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            mag4_reg   <= mag_reg;
            sgn4_reg   <= sgn_reg;
            len_reg[0] <= len1;
            len_reg[1] <= len2;
            neg4_reg   <= !tsum[TW-1] && (tsum != '0);
            degen4_reg <= degen3_reg;
        end
    end

    // stage 5: scale each normal to a 30-bit largest component
    logic signed [NORM_BITS:0] pn_next[6];
    norm_beat_t                beat_reg;

    always_comb begin
        logic [SW-1:0]        sh;
        logic [LW-1:0]        ln;
        logic [NORM_BITS-1:0] m30;
        for (int c = 0; c < 6; c++) begin
            ln = len_reg[c/3];
            if (ln > LW'(NORM_BITS)) begin
                sh = SW'(mag4_reg[c]) >> (ln - LW'(NORM_BITS));
            end else begin
                sh = SW'(mag4_reg[c]) << (LW'(NORM_BITS) - ln);
            end
            m30 = sh[NORM_BITS-1:0];
            pn_next[c] = sgn4_reg[c] ? -$signed({1'b0, m30}) : $signed({1'b0, m30});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            beat_reg.p0    <= pn_next[0];
            beat_reg.p1    <= pn_next[1];
            beat_reg.p2    <= pn_next[2];
            beat_reg.q0    <= pn_next[3];
            beat_reg.q1    <= pn_next[4];
            beat_reg.q2    <= pn_next[5];
            beat_reg.neg   <= neg4_reg;
            beat_reg.degen <= degen4_reg;
        end
    end

    assign out_beat = beat_reg;

endmodule

// ===== hw/rtl/dau_pairs.sv =====
// dot and cross of the scaled normals, joint scaling, squared cross length
// depends on dau_pkg
module dau_pairs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  dau_pkg::norm_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output dau_pkg::pair_beat_t out_beat
);
    import dau_pkg::*;

    localparam int NSTG = 7;
    localparam int SW   = 64 + PAIR_BITS;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    logic signed [NORM_BITS:0] pv[3], qv[3];

    always_comb begin
        pv[0] = $signed(in_beat.p0);
        pv[1] = $signed(in_beat.p1);
        pv[2] = $signed(in_beat.p2);
        qv[0] = $signed(in_beat.q0);
        qv[1] = $signed(in_beat.q1);
        qv[2] = $signed(in_beat.q2);
    end

    // stage 0: products, dot terms first then cross terms
    logic signed [61:0] dp_reg[3], ca_reg[3], cb_reg[3];
    logic [NSTG-2:0]    neg_reg, degen_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                dp_reg[i] <= pv[i] * qv[i];
                ca_reg[i] <= pv[(i+1)%3] * qv[(i+2)%3];
                cb_reg[i] <= pv[(i+2)%3] * qv[(i+1)%3];
            end
            neg_reg[0]   <= in_beat.neg;
            degen_reg[0] <= in_beat.degen;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k < NSTG - 1; k++) begin
            if (en[k]) begin
                neg_reg[k]   <= neg_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    // stage 1: cross components and dot, dot last
    logic signed [63:0] val_reg[4];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                val_reg[i] <= 64'(ca_reg[i]) - 64'(cb_reg[i]);
            end
            val_reg[3] <= 64'(dp_reg[0]) + 64'(dp_reg[1]) + 64'(dp_reg[2]);
        end
    end

    // stage 2: magnitudes
    logic [63:0] mag_reg[4];
    logic [3:0]  sgn_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 4; i++) begin
                mag_reg[i] <= val_reg[i][63] ? $unsigned(-val_reg[i]) : $unsigned(val_reg[i]);
                sgn_reg[i] <= val_reg[i][63];
            end
        end
    end

    // stage 3: leading one over all four
    logic [63:0] mor;
    logic [6:0]  len;
    logic [63:0] mag3_reg[4];
    logic [3:0]  sgn3_reg;
    logic [6:0]  len_reg;

    always_comb begin
        mor = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3];
        len = '0;
        for (int b = 0; b < 64; b++) begin
            if (mor[b]) begin
                len = 7'(b + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            mag3_reg <= mag_reg;
            sgn3_reg <= sgn_reg;
            len_reg  <= len;
        end
    end

    // stage 4: scale to a 31-bit largest magnitude
    logic [PAIR_BITS-1:0] m31[4];
    logic [PAIR_BITS-1:0] xm_reg[3];
    logic signed [PAIR_BITS:0] dot4_reg;

    always_comb begin
        logic [SW-1:0] sh;
        for (int i = 0; i < 4; i++) begin
            if (len_reg > 7'(PAIR_BITS)) begin
                sh = SW'(mag3_reg[i]) >> (len_reg - 7'(PAIR_BITS));
            end else begin
                sh = SW'(mag3_reg[i]) << (7'(PAIR_BITS) - len_reg);
            end
            m31[i] = sh[PAIR_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                xm_reg[i] <= m31[i];
            end
            dot4_reg <= sgn3_reg[3] ? -$signed({1'b0, m31[3]}) : $signed({1'b0, m31[3]});
        end
    end

    // stage 5: squares
    logic [61:0]               sq_reg[3];
    logic signed [PAIR_BITS:0] dot5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 62'(xm_reg[i]) * 62'(xm_reg[i]);
            end
            dot5_reg <= dot4_reg;
        end
    end

    // stage 6: squared length
    pair_beat_t beat_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            beat_reg.sq    <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            beat_reg.dot   <= dot5_reg;
            beat_reg.neg   <= neg_reg[5];
            beat_reg.degen <= degen_reg[5];
        end
    end

    assign out_beat = beat_reg;

endmodule

// ===== hw/rtl/dau_isqrt.sv =====
// pipelined integer square root, two result bits per stage
// depends on dau_pkg
module dau_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  dau_pkg::pair_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output dau_pkg::root_beat_t out_beat
);
    import dau_pkg::*;

    localparam int NSTG = ISQ_STAGES;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    logic [63:0]               rem_reg[NSTG];
    logic [63:0]               rt_reg[NSTG];
    logic signed [PAIR_BITS:0] dot_reg[NSTG];
    logic [NSTG-1:0]           neg_reg, degen_reg;

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic [63:0]               cur_rem, cur_rt;
        logic signed [PAIR_BITS:0] cur_dot;
        logic                      cur_neg, cur_degen;
        logic [63:0]               rem_next, rt_next;

        if (k == 0) begin : g_first
            assign cur_rem   = in_beat.sq;
            assign cur_rt    = '0;
            assign cur_dot   = in_beat.dot;
            assign cur_neg   = in_beat.neg;
            assign cur_degen = in_beat.degen;
        end else begin : g_rest
            assign cur_rem   = rem_reg[k-1];
            assign cur_rt    = rt_reg[k-1];
            assign cur_dot   = dot_reg[k-1];
            assign cur_neg   = neg_reg[k-1];
            assign cur_degen = degen_reg[k-1];
        end

        always_comb begin
            logic [63:0] bt;
            rem_next = cur_rem;
            rt_next  = cur_rt;
            for (int j = 0; j < 2; j++) begin
                bt = 64'd1 << (62 - 2 * (2 * k + j));
                if (rem_next >= rt_next + bt) begin
                    rem_next = rem_next - (rt_next + bt);
                    rt_next  = (rt_next >> 1) + bt;
                end else begin
                    rt_next  = rt_next >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]   <= rem_next;
                rt_reg[k]    <= rt_next;
                dot_reg[k]   <= cur_dot;
                neg_reg[k]   <= cur_neg;
                degen_reg[k] <= cur_degen;
            end
        end
    end

    always_comb begin
        out_beat.root  = rt_reg[NSTG-1][31:0];
        out_beat.dot   = dot_reg[NSTG-1];
        out_beat.neg   = neg_reg[NSTG-1];
        out_beat.degen = degen_reg[NSTG-1];
    end

endmodule

// ===== hw/rtl/dau_cordic.sv =====
// cordic vectoring for atan2(root, dot), clamp, scale to output steps
// depends on dau_pkg
module dau_cordic #(
    parameter int ANGLE_STEPS_PER_DEGREE = 100
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  dau_pkg::root_beat_t          in_beat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dau_pkg::ANGLE_W-1:0]  out_angle,
    output logic                         out_status
);
    import dau_pkg::*;

    localparam int NSTG = CRD_STAGES + 3;
    localparam int SB   = $clog2(ANGLE_STEPS_PER_DEGREE + 1);
    localparam int PRW  = 32 + SB;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    logic signed [CRD_W-1:0] x_reg[CRD_STAGES+1], y_reg[CRD_STAGES+1], z_reg[CRD_STAGES+1];
    logic [CRD_STAGES:0]     neg_reg, degen_reg;

    // entry: parallel case, left half-plane pre-rotation
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            if (in_beat.root == '0) begin
                x_reg[0] <= '0;
                y_reg[0] <= '0;
                z_reg[0] <= in_beat.dot[PAIR_BITS] ? $signed(CRD_W'(DEG180_Q)) : '0;
            end else if (in_beat.dot[PAIR_BITS]) begin
                x_reg[0] <= $signed(CRD_W'(in_beat.root));
                y_reg[0] <= -CRD_W'(in_beat.dot);
                z_reg[0] <= $signed(CRD_W'(DEG90_Q));
            end else begin
                x_reg[0] <= CRD_W'(in_beat.dot);
                y_reg[0] <= $signed(CRD_W'(in_beat.root));
                z_reg[0] <= '0;
            end
            neg_reg[0]   <= in_beat.neg;
            degen_reg[0] <= in_beat.degen;
        end
    end

    for (genvar g = 0; g < CRD_STAGES; g++) begin : g_rot
        logic signed [CRD_W-1:0] x_next, y_next, z_next;

        always_comb begin
            logic signed [CRD_W-1:0] xs, ys;
            x_next = x_reg[g];
            y_next = y_reg[g];
            z_next = z_reg[g];
            for (int j = 0; j < 2; j++) begin
                xs = x_next >>> (2 * g + j);
                ys = y_next >>> (2 * g + j);
                if (y_next != '0) begin
                    if (!y_next[CRD_W-1]) begin
                        x_next = x_next + ys;
                        y_next = y_next - xs;
                        z_next = z_next + $signed(CRD_W'(atan_q24(5'(2 * g + j))));
                    end else begin
                        x_next = x_next - ys;
                        y_next = y_next + xs;
                        z_next = z_next - $signed(CRD_W'(atan_q24(5'(2 * g + j))));
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[g+1]) begin
                x_reg[g+1]     <= x_next;
                y_reg[g+1]     <= y_next;
                z_reg[g+1]     <= z_next;
                neg_reg[g+1]   <= neg_reg[g];
                degen_reg[g+1] <= degen_reg[g];
            end
        end
    end

    // clamp to [0, 180] degrees and scale
    logic [31:0]    zc;
    logic [PRW-1:0] prod_reg;
    logic           negm_reg, degenm_reg;

    always_comb begin
        if (z_reg[CRD_STAGES][CRD_W-1]) begin
            zc = '0;
        end else if (z_reg[CRD_STAGES] > $signed(CRD_W'(DEG180_Q))) begin
            zc = DEG180_Q;
        end else begin
            zc = z_reg[CRD_STAGES][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[CRD_STAGES+1]) begin
            prod_reg   <= PRW'(zc) * PRW'(ANGLE_STEPS_PER_DEGREE);
            negm_reg   <= neg_reg[CRD_STAGES];
            degenm_reg <= degen_reg[CRD_STAGES];
        end
    end

    // round, apply sign, output register
    logic [PRW:0]         rnd;
    logic [PRW:0]         magw;
    logic [ANGLE_W-1:0]   angle_reg;
    logic                 status_reg;

    always_comb begin
        rnd  = (PRW+1)'(prod_reg) + (PRW+1)'(ROUND_HALF);
        magw = rnd >> ACC_FRAC;
    end

    always_ff @(posedge aclk) begin
        if (en[NSTG-1]) begin
            if (degenm_reg) begin
                angle_reg <= '0;
            end else if (negm_reg) begin
                angle_reg <= ANGLE_W'(-magw);
            end else begin
                angle_reg <= ANGLE_W'(magw);
            end
            status_reg <= degenm_reg;
        end
    end

    assign out_angle  = angle_reg;
    assign out_status = status_reg;

endmodule

// ===== hw/rtl/dihedral_angle_unit.sv =====
// top level of the dihedral angle unit: stream ports and section chaining
// depends on dau_pkg, dau_normals, dau_pairs, dau_isqrt, dau_cordic
//
// Input channel s_*: one beat carries four points a, b, c, d, each x/y/z
// a signed COORD_BITS field in 1/256 unit steps. Result channel m_*: the
// signed torsion angle in 1/ANGLE_STEPS_PER_DEGREE degree on m_tdata and a
// degenerate flag on m_tuser (angle is zero when it is set).
// Throughput is one beat per cycle while m_tready is high. From input accept
// to m_tvalid the stages are 6 for normals and sign test, 7 for dot/cross and
// scaling, 16 for the square root (two root bits per stage), 15 for the
// cordic (two iterations per stage), clamp, scaling and output register.
// Every stage holds a valid bit and advances when it is empty or the next
// stage advances, so bubbles close up while m_tready is low and s_tready
// drops only once the whole pipeline is full. Nothing is dropped or
// repeated. Synchronous reset clears all valid bits; data registers are
// not reset.
`include "dihedral_angle_unit_macros.svh"
module dihedral_angle_unit #(
    parameter int COORD_BITS             = 20,
    parameter int ANGLE_STEPS_PER_DEGREE = 100
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_x a_y a_z b_x b_y b_z c_x c_y c_z d_x d_y d_z, zero padded
    input  logic [((12*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // angle
    output logic [dau_pkg::ANGLE_W-1:0]           m_tdata,
    // status
    output logic                                  m_tuser
);
    import dau_pkg::*;

    logic       nrm_valid, nrm_ready;
    norm_beat_t nrm_beat;
    logic       par_valid, par_ready;
    pair_beat_t par_beat;
    logic       rt_valid, rt_ready;
    root_beat_t rt_beat;

    dau_normals #(
        .COORD_BITS (COORD_BITS)
    ) u_normals (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pts    (s_tdata[12*COORD_BITS-1:0]),
        .out_valid (nrm_valid),
        .out_ready (nrm_ready),
        .out_beat  (nrm_beat)
    );

    dau_pairs u_pairs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (nrm_valid),
        .in_ready  (nrm_ready),
        .in_beat   (nrm_beat),
        .out_valid (par_valid),
        .out_ready (par_ready),
        .out_beat  (par_beat)
    );

    dau_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (par_valid),
        .in_ready  (par_ready),
        .in_beat   (par_beat),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_beat  (rt_beat)
    );

    dau_cordic #(
        .ANGLE_STEPS_PER_DEGREE (ANGLE_STEPS_PER_DEGREE)
    ) u_cordic (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rt_valid),
        .in_ready   (rt_ready),
        .in_beat    (rt_beat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_angle  (m_tdata),
        .out_status (m_tuser)
    );

    `DAU_ASSERT(a_degen_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0))
    `DAU_ASSERT(a_stall_full, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready))
    `DAU_ASSERT(a_ready_empty, aclk, aresetn, !m_tvalid |-> s_tready)
    `DAU_ASSERT_NR(a_reset_clear, aclk, !aresetn |=> !m_tvalid)

endmodule

// ===== tb/dihedral_angle_checker.sv =====
// stream checker for the dihedral angle unit: predicts torsion angles from input beats
// and compares them against result beats; depends on dau_pkg for the angle and scaling widths
module dihedral_angle_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [239:0]                s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [dau_pkg::ANGLE_W-1:0] m_tdata,
    input  logic                        m_tuser,
    output int                          pending,
    output int                          failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dau_pkg::ANGLE_W-1:0] angle;
        logic                        degen;
    } torsion_t;

    typedef logic signed [127:0] wide_t;

    torsion_t torsion_q[$];

    localparam longint ATAN_Q24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115};

    function automatic void scale_pow2(input wide_t v[4], input int n, input int bits,
                                       output longint o[4]);
        wide_t mx;
        wide_t m;
        int len;
        mx = 0;
        len = 0;
        for (int i = 0; i < n; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            if (m > mx) mx = m;
        end
        for (int b = 0; b < 128; b++) if (mx[b]) len = b + 1;
        for (int i = 0; i < 4; i++) o[i] = 0;
        for (int i = 0; i < n; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            m = len > bits ? (m >> (len - bits)) : (m << (bits - len));
            o[i] = v[i] < 0 ? -longint'(m) : longint'(m);
        end
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= r + bit_w) begin
                v -= r + bit_w;
                r = (r >> 1) + bit_w;
            end else begin
                r >>= 1;
            end
            bit_w >>= 2;
        end
        return r;
    endfunction

    function automatic torsion_t predict_torsion(input logic [239:0] d);
        wide_t pt[12], u[3], v[3], w[3], n1[4], n2[4], pw[4], t;
        longint p[4], q[4], pr[4], dot, x, y, z, nx, ny;
        longint unsigned s, mag;
        logic negative;
        torsion_t r;
        for (int i = 0; i < 12; i++) pt[i] = wide_t'(signed'(d[i*20 +: 20]));
        for (int i = 0; i < 3; i++) begin
            u[i] = pt[3+i] - pt[i];
            v[i] = pt[6+i] - pt[3+i];
            w[i] = pt[9+i] - pt[6+i];
        end
        n1[0] = u[1]*v[2] - u[2]*v[1];
        n1[1] = u[2]*v[0] - u[0]*v[2];
        n1[2] = u[0]*v[1] - u[1]*v[0];
        n2[0] = v[1]*w[2] - v[2]*w[1];
        n2[1] = v[2]*w[0] - v[0]*w[2];
        n2[2] = v[0]*w[1] - v[1]*w[0];
        n1[3] = 0;
        n2[3] = 0;
        r.angle = '0;
        r.degen = 1'b1;
        if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
            (n2[0] == 0 && n2[1] == 0 && n2[2] == 0))
            return r;
        r.degen = 1'b0;
        t = n1[0]*w[0] + n1[1]*w[1] + n1[2]*w[2];
        negative = t > 0;
        scale_pow2(n1, 3, dau_pkg::NORM_BITS, p);
        scale_pow2(n2, 3, dau_pkg::NORM_BITS, q);
        dot = p[0]*q[0] + p[1]*q[1] + p[2]*q[2];
        pw[0] = wide_t'(p[1]*q[2] - p[2]*q[1]);
        pw[1] = wide_t'(p[2]*q[0] - p[0]*q[2]);
        pw[2] = wide_t'(p[0]*q[1] - p[1]*q[0]);
        pw[3] = wide_t'(dot);
        scale_pow2(pw, 4, dau_pkg::PAIR_BITS, pr);
        s = root_floor(longint'(pr[0]*pr[0]) + longint'(pr[1]*pr[1])
                       + longint'(pr[2]*pr[2]));
        if (s == 0) begin
            z = pr[3] >= 0 ? 0 : (longint'(180) << 24);
        end else begin
            x = pr[3];
            y = longint'(s);
            z = 0;
            if (x < 0) begin
                nx = y;
                y = -x;
                x = nx;
                z = longint'(90) << 24;
            end
            for (int i = 0; i < 24 && y != 0; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += ATAN_Q24[i];
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= ATAN_Q24[i];
                end
                x = nx;
                y = ny;
            end
            if (z < 0) z = 0;
            if (z > (longint'(180) << 24)) z = longint'(180) << 24;
        end
        mag = (longint'(z) * 100 + (64'd1 << 23)) >> 24;
        r.angle = negative ? 16'(-mag) : 16'(mag);
        return r;
    endfunction

    assign pending = torsion_q.size();

    always @(posedge aclk) begin
        torsion_t exp_r;
        if (!aresetn) begin
            failures <= failures;
        end else begin
            if (s_tvalid && s_tready) torsion_q.push_back(predict_torsion(s_tdata));
            if (m_tvalid && m_tready) begin
                if (torsion_q.size() == 0) begin
                    $error("result beat with nothing expected: angle %0d status %0d",
                           $signed(m_tdata), m_tuser);
                    failures <= failures + 1;
                end else begin
                    exp_r = torsion_q.pop_front();
                    if (exp_r.angle !== m_tdata || exp_r.degen !== m_tuser) begin
                        if (exp_r.angle !== m_tdata)
                            $error("angle: expected %0d actual %0d",
                                   $signed(exp_r.angle), $signed(m_tdata));
                        if (exp_r.degen !== m_tuser)
                            $error("status: expected %0d actual %0d", exp_r.degen, m_tuser);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end

    initial failures = 0;

endmodule

// ===== tb/tb_dihedral_angle_unit.sv =====
// testbench top for the dihedral angle unit: clock, reset, point stimulus, verdict
// depends on dihedral_angle_unit, dau_pkg and dihedral_angle_checker
module tb_dihedral_angle_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 500000;
    localparam int MINC = -524288;
    localparam int MAXC = 524287;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [239:0]                s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [dau_pkg::ANGLE_W-1:0] m_tdata;
    logic                        m_tuser;
    int                          pending;
    int                          failures;
    int                          cycles;
    logic                        hold_off;

    dihedral_angle_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    dihedral_angle_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .pending(pending), .failures(failures)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rnd_coord();
        return int'($urandom_range(0, 20'hfffff)) + MINC;
    endfunction

    function automatic logic [239:0] pack_pts(input int c[12]);
        logic [239:0] d;
        for (int i = 0; i < 12; i++) d[i*20 +: 20] = c[i][19:0];
        return d;
    endfunction

    function automatic logic [239:0] random_quad();
        int c[12];
        int base, span, k, mode;
        mode = $urandom_range(0, 9);
        span = 1 << $urandom_range(1, 17);
        base = $urandom_range(0, 1) ? rnd_coord() / 2 : 0;
        for (int i = 0; i < 12; i++) begin
            if (mode < 4) c[i] = rnd_coord();
            else c[i] = base + int'($urandom_range(0, 2*span)) - span;
        end
        if (mode == 8) begin
            // d in plane abc: cis or trans
            k = $urandom_range(0, 1) ? 1 : -1;
            for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + k * (c[i] - c[3+i]);
        end else if (mode == 9) begin
            // c on line ab
            for (int i = 0; i < 3; i++) c[6+i] = c[3+i] + (c[3+i] - c[i]);
        end
        return pack_pts(c);
    endfunction

    task automatic send_quad(input logic [239:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        bit long_done;
        long_done = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off && !long_done) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("tb_dihedral_angle_unit: errors");
                $finish;
            end
        end
    end

    initial begin
        int c[12];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        hold_off = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all points equal (zero, then MAXC): degenerate
        c = '{default: 0};
        send_quad(pack_pts(c));
        c = '{default: MAXC};
        send_quad(pack_pts(c));
        // unit frames: 90, trans, cis, -90
        c = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, 256};
        send_quad(pack_pts(c));
        c = '{256, 0, 0, 0, 0, 0, 0, 256, 0, -256, 256, 0};
        send_quad(pack_pts(c));
        c = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, 0};
        send_quad(pack_pts(c));
        c = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, -256};
        send_quad(pack_pts(c));
        // extremes
        c = '{MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC};
        send_quad(pack_pts(c));
        c = '{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MINC};
        send_quad(pack_pts(c));
        c = '{MINC, 0, 0, 0, MAXC, 0, 0, 0, MAXC, MAXC, MINC, MINC};
        send_quad(pack_pts(c));
        c = '{MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC};
        send_quad(pack_pts(c));
        // b equals c: degenerate both normals
        c = '{1, 2, 3, 9, 9, 9, 9, 9, 9, 4, -5, 6};
        send_quad(pack_pts(c));
        // tiny near-cis and near-trans twists
        c = '{MAXC, 0, 0, 0, 0, 0, 0, MAXC, 0, MAXC, MAXC, 1};
        send_quad(pack_pts(c));
        c = '{MAXC, 0, 0, 0, 0, 0, 0, MAXC, 0, MINC, MAXC, -1};
        send_quad(pack_pts(c));
        c = '{MAXC, 0, 0, 0, 0, 0, 0, MAXC, 0, MINC, MAXC, 1};
        send_quad(pack_pts(c));

        for (int n = 0; n < 1700; n++) begin
            if (n == 500) begin
                s_tvalid <= 1'b0;
                while (pending != 0) @(posedge aclk);
            end
            if (n == 900) hold_off = 1'b1;
            if (n == 960) hold_off = 1'b0;
            send_quad(random_quad());
        end
        s_tvalid <= 1'b0;
        hold_off = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (failures == 0) begin
            $display("tb_dihedral_angle_unit: clean");
        end else begin
            $display("tb_dihedral_angle_unit: errors");
        end
        $finish;
    end

endmodule
